// ----- rtl/core/aat_pkg.sv -----
package aat_pkg;

  // coordinate range of the world box, limited to the 32-bit field width
  localparam int COORD_BITS = 32;
  localparam int SatBits = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 2) ? 2 : COORD_BITS);

  localparam int CoordW   = 32;
  localparam int HalfW    = CoordW - 1;
  localparam int Axes     = 3;
  localparam int RowTerms = Axes + 1;
  localparam int FracBits = 16;
  localparam int ProdW    = 2 * CoordW;
  localparam int SumW     = ProdW + 2;
  localparam int MapW     = SumW - FracBits + 1;
  localparam int SpanW    = CoordW + 1;

  localparam logic [CoordW-1:0] QOne = CoordW'(1 << FracBits);

  localparam longint SatHi = (longint'(1) <<< (SatBits - 1)) - 1;
  localparam longint SatLo = -SatHi - 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [HalfW-1:0]         half_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_BOX  = 1'b1
  } kind_t;

  // coef[0..2] multiply x, y, z; coef[3] is the row offset
  typedef struct packed {
    kind_t                   kind;
    logic [1:0]              row_index;
    coord_t [RowTerms-1:0]   coef;
    coord_t [Axes-1:0]       lo;
    coord_t [Axes-1:0]       hi;
  } in_word_t;

  // products indexed [axis][column], against the min and the max corner
  typedef struct packed {
    prod_t [Axes-1:0][Axes-1:0] p_lo;
    prod_t [Axes-1:0][Axes-1:0] p_hi;
    coord_t [Axes-1:0]          offset;
  } prod_word_t;

  typedef struct packed {
    sum_t [Axes-1:0]   sum_min;
    sum_t [Axes-1:0]   sum_max;
    coord_t [Axes-1:0] offset;
  } sum_word_t;

  typedef struct packed {
    coord_t [Axes-1:0] wmin;
    coord_t [Axes-1:0] wmax;
  } box_t;

  typedef struct packed {
    box_t              box;
    coord_t [Axes-1:0] center;
    half_t [Axes-1:0]  half;
  } result_t;

  // floor shift of the exact sum, add offset, saturate
  function automatic coord_t map_coord(input sum_t sum, input coord_t offset);
    logic signed [MapW-1:0] v;
    longint                 vl;
    v  = MapW'(sum >>> FracBits) + MapW'(offset);
    vl = 64'(v);
    if (vl > SatHi) begin
      return coord_t'(SatHi);
    end
    if (vl < SatLo) begin
      return coord_t'(SatLo);
    end
    return coord_t'(vl);
  endfunction

endpackage

// ----- rtl/core/aat_matrix.sv -----
module aat_matrix import aat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  in_word_t   in_word,
  output logic       take,
  output logic       out_valid,
  output prod_word_t out_word,
  input  logic       out_ready
);

  coord_t [Axes-1:0][RowTerms-1:0] matrix;
  prod_word_t                      prod_next;
  logic                            is_load;
  logic                            ready;

  assign is_load = (in_word.kind == KIND_LOAD);
  assign ready   = !out_valid || out_ready;
  // a load word only touches the matrix, so it never waits
  assign take    = in_valid && (is_load || ready);

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      for (int i = 0; i < Axes; i++) begin
        prod_next.p_lo[a][i] = ProdW'($signed(matrix[a][i])) * ProdW'($signed(in_word.lo[i]));
        prod_next.p_hi[a][i] = ProdW'($signed(matrix[a][i])) * ProdW'($signed(in_word.hi[i]));
      end
      prod_next.offset[a] = matrix[a][Axes];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int r = 0; r < Axes; r++) begin
        for (int c = 0; c < RowTerms; c++) begin
          matrix[r][c] <= (r == c) ? QOne : '0;
        end
      end
    end else begin
      if (take && is_load && (in_word.row_index < 2'(Axes))) begin
        matrix[in_word.row_index] <= in_word.coef;
      end
      if (ready) begin
        out_valid <= in_valid && !is_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !is_load) begin
      out_word <= prod_next;
    end
  end

endmodule

// ----- rtl/core/aat_bound.sv -----
module aat_bound import aat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  prod_word_t in_word,
  output logic       in_ready,
  output logic       out_valid,
  output box_t       out_word,
  input  logic       out_ready
);

  logic      sum_valid;
  sum_word_t sum_word;
  sum_word_t sum_next;
  box_t      box_next;
  logic      box_ready;

  assign box_ready = !out_valid || out_ready;
  assign in_ready  = !sum_valid || box_ready;

  // extremes of a sum of independent terms: pick each term's extreme
  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      sum_next.sum_min[a] = '0;
      sum_next.sum_max[a] = '0;
      for (int i = 0; i < Axes; i++) begin
        if ($signed(in_word.p_lo[a][i]) < $signed(in_word.p_hi[a][i])) begin
          sum_next.sum_min[a] = sum_next.sum_min[a] + SumW'($signed(in_word.p_lo[a][i]));
          sum_next.sum_max[a] = sum_next.sum_max[a] + SumW'($signed(in_word.p_hi[a][i]));
        end else begin
          sum_next.sum_min[a] = sum_next.sum_min[a] + SumW'($signed(in_word.p_hi[a][i]));
          sum_next.sum_max[a] = sum_next.sum_max[a] + SumW'($signed(in_word.p_lo[a][i]));
        end
      end
      sum_next.offset[a] = in_word.offset[a];
    end
  end

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      box_next.wmin[a] = map_coord(sum_word.sum_min[a], sum_word.offset[a]);
      box_next.wmax[a] = map_coord(sum_word.sum_max[a], sum_word.offset[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        sum_valid <= in_valid;
      end
      if (box_ready) begin
        out_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sum_word <= sum_next;
    end
    if (box_ready && sum_valid) begin
      out_word <= box_next;
    end
  end

endmodule

// ----- rtl/core/aat_finish.sv -----
module aat_finish import aat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  box_t    in_word,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_word,
  input  logic    out_stall
);

  result_t                  res_next;
  logic signed [SpanW-1:0]  total;
  logic signed [SpanW-1:0]  span;

  assign in_ready = !out_valid || !out_stall;

  always_comb begin
    total = '0;
    span  = '0;
    res_next.box = in_word;
    for (int a = 0; a < Axes; a++) begin
      total = SpanW'($signed(in_word.wmin[a])) + SpanW'($signed(in_word.wmax[a]));
      span  = SpanW'($signed(in_word.wmax[a])) - SpanW'($signed(in_word.wmin[a]));
      res_next.center[a] = total[SpanW-1:1];
      res_next.half[a]   = span[HalfW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= res_next;
    end
  end

endmodule

// ----- rtl/core/affine_aabb_transform.sv -----
// a box word passes the input, product, sum, box and result registers on its way to the result port
// throughput: one word per cycle while no stall backs up; load words pass through the input register
// and the matrix row write, and give no result
// stalls back up stage by stage, so empty stages still take new words
// reset is synchronous: all stages empty, matrix set to identity
module affine_aabb_transform import aat_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid,
  output logic         stall,
  input  logic         kind,
  input  logic [1:0]   row_index,
  input  logic signed [31:0] coef_x,
  input  logic signed [31:0] coef_y,
  input  logic signed [31:0] coef_z,
  input  logic signed [31:0] coef_offset,
  input  logic signed [31:0] min_x,
  input  logic signed [31:0] min_y,
  input  logic signed [31:0] min_z,
  input  logic signed [31:0] max_x,
  input  logic signed [31:0] max_y,
  input  logic signed [31:0] max_z,
  output logic         res_valid,
  input  logic         res_stall,
  output logic signed [31:0] world_min_x,
  output logic signed [31:0] world_min_y,
  output logic signed [31:0] world_min_z,
  output logic signed [31:0] world_max_x,
  output logic signed [31:0] world_max_y,
  output logic signed [31:0] world_max_z,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic signed [31:0] center_z,
  output logic [30:0]  half_x,
  output logic [30:0]  half_y,
  output logic [30:0]  half_z
);

  logic       in_reg_valid;
  in_word_t   in_reg;
  in_word_t   in_next;
  logic       mat_take;
  logic       prod_valid;
  prod_word_t prod_word;
  logic       bound_ready;
  logic       box_valid;
  box_t       box_word;
  logic       finish_ready;
  result_t    result;
  logic       accept;

  assign stall  = in_reg_valid && !mat_take;
  assign accept = valid && !stall;

  always_comb begin
    in_next.kind      = kind_t'(kind);
    in_next.row_index = row_index;
    in_next.coef      = {coef_offset, coef_z, coef_y, coef_x};
    in_next.lo        = {min_z, min_y, min_x};
    in_next.hi        = {max_z, max_y, max_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (mat_take) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_next;
    end
  end

  aat_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_reg_valid),
    .in_word   (in_reg),
    .take      (mat_take),
    .out_valid (prod_valid),
    .out_word  (prod_word),
    .out_ready (bound_ready)
  );

  aat_bound u_bound (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_word   (prod_word),
    .in_ready  (bound_ready),
    .out_valid (box_valid),
    .out_word  (box_word),
    .out_ready (finish_ready)
  );

  aat_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (box_valid),
    .in_word   (box_word),
    .in_ready  (finish_ready),
    .out_valid (res_valid),
    .out_word  (result),
    .out_stall (res_stall)
  );

  assign world_min_x = result.box.wmin[0];
  assign world_min_y = result.box.wmin[1];
  assign world_min_z = result.box.wmin[2];
  assign world_max_x = result.box.wmax[0];
  assign world_max_y = result.box.wmax[1];
  assign world_max_z = result.box.wmax[2];
  assign center_x    = result.center[0];
  assign center_y    = result.center[1];
  assign center_z    = result.center[2];
  assign half_x      = result.half[0];
  assign half_y      = result.half[1];
  assign half_z      = result.half[2];

endmodule

// ----- rtl/core/aat_checker.sv -----
module aat_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input logic signed [31:0] world_min_x,
  input logic signed [31:0] world_max_x,
  input logic signed [31:0] center_x,
  input logic [30:0]        half_x
);

  logic signed [32:0] span_x;

  assign span_x = 33'(world_max_x) - 33'(world_min_x);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(world_min_x) && $stable(center_x))
    else $error("stalled result word changed");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (world_min_x <= world_max_x) && (center_x >= world_min_x)
                  && (center_x <= world_max_x))
    else $error("world box min, center and max out of order");

  a_half_span: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> half_x == span_x[31:1])
    else $error("half width does not match the box span");

endmodule

bind affine_aabb_transform aat_checker u_aat_checker (.*);
